// File: rtl/epn_pkg.sv
package epn_pkg;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_EMBED  = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [8:0]         row_index;
    logic [8:0]         col_index;
    logic signed [15:0] value;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [8:0]         out_index;
    logic signed [31:0] out_value;
    logic               zero_norm;
    logic               saturated;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_RD,
    ST_NORM_ACC,
    ST_SQRT,
    ST_DOT_RD,
    ST_DOT_ACC,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// File: rtl/epn_ram.sv
module epn_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/epn_sqrt.sv
module epn_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  // Digit-by-digit root, two radicand bits per cycle.
  logic [63:0] rad_q;
  logic [31:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        run_q;
  logic [33:0] shifted;
  logic [33:0] cand;
  logic [33:0] diff;
  logic        ge;

  assign shifted = {rem_q, rad_q[63:62]};
  assign cand    = {root_q, 2'b01};
  assign diff    = shifted - cand;
  assign ge      = (shifted >= cand);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 5'd1;
      run_q <= (cnt_q != 5'd31);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= ge ? diff[31:0] : shifted[31:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = run_q && (cnt_q == 5'd31);
  assign root_o = {root_q[30:0], ge};

endmodule

// File: rtl/epn_div.sv
module epn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] dvs_q;
  logic [6:0]  cnt_q;
  logic        run_q;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem_q[31:0], quo_q[63]};
  assign ge = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 7'd1;
      run_q <= (cnt_q != 7'd63);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? sh - {1'b0, dvs_q} : sh;
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = run_q && (cnt_q == 7'd63);
  assign quot_o = {quo_q[62:0], ge};

endmodule

// File: rtl/embedding_projection_normalized.sv
// One word is taken whenever start is high and busy is low. An embedding
// write with last set also recomputes the norm: the stored elements, up to
// the length L in use, are read and accumulated, then their square root is
// taken, with busy high throughout. An output request with a non-zero norm
// and an index below L reads one weight and one embedding element per cycle,
// then divides by the norm and registers the word, with busy high; any other
// request keeps busy high for one cycle. The result word is presented for
// exactly one cycle with out_valid_o, in the first cycle after busy falls,
// and the receiver cannot hold it off.
module embedding_projection_normalized #(
  parameter int unsigned MaxLen = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  epn_pkg::in_word_t     in_word_i,
  output logic                  out_valid_o,
  output epn_pkg::out_word_t    out_word_o,
  input  logic                  cfg_we_i,
  input  logic [9:0]            cfg_wdata_i
);

  localparam int unsigned AW  = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned WAW = 2 * AW;
  localparam int unsigned CW  = AW + 1;

  epn_pkg::state_e state_q, state_d;
  logic [9:0]  vlen_q;
  logic [31:0] norm_q;
  logic [CW-1:0] len;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;
  logic [63:0] acc_q, acc_d;
  logic [8:0]  col_q;
  logic        accept;

  logic        e_we, w_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [15:0] e_rdata, w_rdata;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic        dv_start, dv_done;
  logic [63:0] dv_quot;
  logic        sq_pend_q, dv_pend_q;
  logic        neg;
  logic [63:0] mag;
  logic signed [31:0] prod;
  logic [63:0] q;
  logic        sat;
  logic signed [31:0] res;

  assign len    = (11'(vlen_q) > 11'(MaxLen)) ? CW'(MaxLen) : CW'(vlen_q);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= 10'd512;
    end else if (cfg_we_i) begin
      vlen_q <= cfg_wdata_i;
    end
  end

  assign e_we    = accept && (in_word_i.mode == epn_pkg::MODE_EMBED)
                   && (11'(in_word_i.row_index) < 11'(MaxLen));
  assign e_waddr = AW'(in_word_i.row_index);
  assign w_we    = accept && (in_word_i.mode == epn_pkg::MODE_WEIGHT)
                   && (11'(in_word_i.row_index) < 11'(MaxLen))
                   && (11'(in_word_i.col_index) < 11'(MaxLen));
  assign w_waddr = {AW'(in_word_i.row_index), AW'(in_word_i.col_index)};
  assign e_raddr = AW'(j_q);
  assign w_raddr = {AW'(j_q), AW'(col_q)};

  epn_ram #(.Width(16), .Depth(1 << AW)) u_emb (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(in_word_i.value),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  epn_ram #(.Width(16), .Depth(1 << WAW)) u_wgt (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(in_word_i.value),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  assign prod = (state_q == epn_pkg::ST_NORM_ACC)
                ? $signed(e_rdata) * $signed(e_rdata)
                : $signed(e_rdata) * $signed(w_rdata);

  epn_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .radicand_i({acc_q[53:0], 10'd0}),
    .done_o(sq_done), .root_o(sq_root)
  );

  assign neg = acc_q[63];
  assign mag = neg ? (64'd0 - acc_q) : acc_q;

  epn_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start),
    .dividend_i({mag[56:0], 7'd0} + {33'd0, norm_q[31:1]}),
    .divisor_i(norm_q), .done_o(dv_done), .quot_o(dv_quot)
  );

  always_comb begin
    state_d  = state_q;
    j_d      = j_q;
    k_d      = k_q;
    acc_d    = acc_q;
    busy     = 1'b1;
    case (state_q)
      epn_pkg::ST_IDLE: begin
        busy = 1'b0;
        j_d  = '0;
        k_d  = '0;
        acc_d = '0;
        if (accept && in_word_i.mode == epn_pkg::MODE_EMBED && in_word_i.last) begin
          state_d = epn_pkg::ST_NORM_RD;
        end else if (accept && in_word_i.mode == epn_pkg::MODE_QUERY) begin
          if (norm_q == 32'd0 || 11'(in_word_i.col_index) >= 11'(len)) begin
            state_d = epn_pkg::ST_DONE;
          end else begin
            state_d = epn_pkg::ST_DOT_RD;
          end
        end
      end
      epn_pkg::ST_NORM_RD, epn_pkg::ST_DOT_RD: begin
        if (len == '0) begin
          state_d = (state_q == epn_pkg::ST_NORM_RD) ? epn_pkg::ST_SQRT
                                                    : epn_pkg::ST_DIV;
        end else begin
          j_d = j_q + CW'(1);
          state_d = (state_q == epn_pkg::ST_NORM_RD) ? epn_pkg::ST_NORM_ACC
                                                    : epn_pkg::ST_DOT_ACC;
        end
      end
      epn_pkg::ST_NORM_ACC, epn_pkg::ST_DOT_ACC: begin
        acc_d = acc_q + 64'(prod);
        k_d   = k_q + CW'(1);
        if (j_q < len) begin
          j_d = j_q + CW'(1);
        end
        if (k_q + CW'(1) == len) begin
          if (state_q == epn_pkg::ST_NORM_ACC) begin
            state_d = epn_pkg::ST_SQRT;
          end else begin
            state_d = epn_pkg::ST_DIV;
          end
        end
      end
      epn_pkg::ST_SQRT: begin
        if (sq_done) begin
          state_d = epn_pkg::ST_IDLE;
        end
      end
      epn_pkg::ST_DIV: begin
        if (dv_done) begin
          state_d = epn_pkg::ST_DONE;
        end
      end
      epn_pkg::ST_DONE: begin
        state_d = epn_pkg::ST_IDLE;
      end
      default: begin
        state_d = epn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= epn_pkg::ST_IDLE;
      norm_q    <= '0;
      sq_pend_q <= 1'b0;
      dv_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sq_pend_q <= (state_q != epn_pkg::ST_SQRT) && (state_d == epn_pkg::ST_SQRT);
      dv_pend_q <= (state_q != epn_pkg::ST_DIV) && (state_d == epn_pkg::ST_DIV);
      if (state_q == epn_pkg::ST_SQRT && sq_done) begin
        norm_q <= sq_root;
      end
    end
  end

  // The accumulator takes in the last product in the next cycle, so the
  // start strobes are registered and the iterative units are launched from that registered value.
  assign sq_start = sq_pend_q;
  assign dv_start = dv_pend_q;

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    k_q   <= k_d;
    acc_q <= acc_d;
    if (accept) begin
      col_q <= in_word_i.col_index;
    end
  end

  assign q = dv_quot;

  always_comb begin
    sat = 1'b0;
    res = '0;
    if (!neg && q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      res = 32'sh7FFF_FFFF;
    end else if (neg && q > 64'h8000_0000) begin
      sat = 1'b1;
      res = 32'sh8000_0000;
    end else begin
      res = neg ? 32'(64'd0 - q) : q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= (state_q == epn_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == epn_pkg::ST_DIV && dv_done) begin
      out_word_o.out_value <= res;
      out_word_o.saturated <= sat;
    end else if (state_q == epn_pkg::ST_IDLE) begin
      out_word_o.out_value <= '0;
      out_word_o.saturated <= 1'b0;
    end
    if (state_q == epn_pkg::ST_DONE) begin
      out_word_o.out_index <= col_q;
      out_word_o.zero_norm <= (norm_q == 32'd0);
    end
  end

  a_busy_when_working : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != epn_pkg::ST_IDLE) |-> busy) else $error("busy low while working");
  a_result_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("result strobe longer than one cycle");
  a_zero_norm_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.zero_norm) |-> (out_word_o.out_value == '0))
    else $error("zero norm with non-zero value");

endmodule
